@@ rtl/ump_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ump_pkg;

  // regime codes of a result beat
  typedef enum logic [1:0] {
    RG_LOS_NEAR   = 2'd0,
    RG_LOS_FAR    = 2'd1,
    RG_NLOS       = 2'd2,
    RG_FREE_SPACE = 2'd3
  } regime_t;

  // configuration register indexes
  localparam logic CFG_CARRIER = 1'b0;
  localparam logic CFG_HEIGHT  = 1'b1;

  localparam int CFG_W = 13;
  localparam int LG_W  = 20;   // log values in Q16
  localparam int SUM_W = 40;   // loss sums in 1/(100*65536) dB

  localparam logic [31:0] LOG10_2_Q32 = 32'd1292913986;

  typedef struct packed {
    logic [15:0] link_distance;
    logic        nlos_building;
    logic [9:0]  added_loss;
  } in_t;

  typedef struct packed {
    logic [11:0] loss_db;
    regime_t     regime;
  } out_t;

  // log2(z0 / 2^30) in Q16 by repeated squaring, z0 in [2^30, 2^31)
  function automatic logic [15:0] log_frac(input logic [63:0] z0);
    logic [63:0] z;
    logic [15:0] acc;
    z   = z0;
    acc = '0;
    for (int b = 15; b >= 0; b--) begin
      z = (z * z) >> 30;
      if (z >= (64'd1 << 31)) begin
        acc[b] = 1'b1;
        z      = z >> 1;
      end
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

@@ rtl/urban_microcell_path_loss_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake              Payload
// in_      input      in_valid / in_stall     ump_pkg::in_t
// out_     output     out_valid / out_stall   ump_pkg::out_t
// cfg_     input      cfg_wr_en               cfg_addr, cfg_wdata
//
// One link a cycle while the output is not stalled; the pipeline has ten stages
// (log unit, constant products, slope multiply, rounding divide by 25).
// Synchronous active-low reset clears the valid bits and restores the registers.
// A stall holds only the stages that are full up to the output, so bubbles close up.
// Carrier and height terms settle in free-running registers after a register write.
module urban_microcell_path_loss_top #(
  parameter int DIST_FRAC_BITS  = 4,
  parameter int LOG_TABLE_DEPTH = 256
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire ump_pkg::in_t                in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output ump_pkg::out_t                    out_data,
  input  wire logic                        cfg_wr_en,
  input  wire logic                        cfg_addr,
  input  wire logic [ump_pkg::CFG_W-1:0]   cfg_wdata
);

  localparam int NS   = 10;
  localparam int SW   = ump_pkg::SUM_W;
  localparam int RHSW = 38 + DIST_FRAC_BITS;
  localparam logic [15:0] DMIN = 16'(3 << DIST_FRAC_BITS);

  // log10(5000) in Q16, same table path as runtime
  localparam logic [63:0] IDX5 = (64'd7232 * 64'(LOG_TABLE_DEPTH)) >> 15;
  localparam logic [63:0] Z5   = (64'd1 << 30) + ((IDX5 << 30) / LOG_TABLE_DEPTH);
  localparam logic [63:0] L2_5 = 64'(12 * 65536) + 64'(ump_pkg::log_frac(Z5));
  localparam logic [63:0] LG5  = (L2_5 * 64'(ump_pkg::LOG10_2_Q32)) >> 32;

  localparam logic signed [SW-1:0] Q16S = 40'sd65536;

  // ---------------- configuration ----------------
  logic [12:0] carrier_r, height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carrier_r <= 13'd5900;
      height_r  <= 13'd150;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        ump_pkg::CFG_CARRIER: carrier_r <= cfg_wdata;
        ump_pkg::CFG_HEIGHT:  height_r  <= cfg_wdata;
      endcase
    end
  end

  logic [12:0] f_cl, h_cl, hm;

  assign f_cl = (carrier_r < 13'd700)  ? 13'd700  :
                (carrier_r > 13'd6000) ? 13'd6000 : carrier_r;
  assign h_cl = (height_r < 13'd110)   ? 13'd110  :
                (height_r > 13'd5000)  ? 13'd5000 : height_r;
  assign hm   = h_cl - 13'd100;

  // free-running lane for the carrier/height terms
  logic [24:0]      hc2_r;
  logic [RHSW-1:0]  rhs_r;
  logic [25:0]      hsq;

  assign hsq = 26'(hm) * 26'(hm);

  always_ff @(posedge clk) begin
    hc2_r <= hsq[24:0];
    rhs_r <= RHSW'(38'(hc2_r) * 38'(f_cl)) << DIST_FRAC_BITS;
  end

  logic [ump_pkg::LG_W-1:0] lgf, lgh, lgh1;

  ump_log10 #(.DEPTH(LOG_TABLE_DEPTH), .L2_SUB(0)) u_lg_f (
    .clk(clk), .en(3'b111), .x(16'(f_cl)), .lg(lgf)
  );
  ump_log10 #(.DEPTH(LOG_TABLE_DEPTH), .L2_SUB(0)) u_lg_h (
    .clk(clk), .en(3'b111), .x(16'(h_cl)), .lg(lgh)
  );
  ump_log10 #(.DEPTH(LOG_TABLE_DEPTH), .L2_SUB(0)) u_lg_h1 (
    .clk(clk), .en(3'b111), .x(16'(hm)), .lg(lgh1)
  );

  logic signed [SW-1:0] lf_x, lf5_x, lh_x, lh1_x;

  assign lf_x  = SW'(lgf)  - 40'sd3 * Q16S;
  assign lf5_x = SW'(lgf)  - SW'(LG5);
  assign lh_x  = SW'(lgh)  - 40'sd2 * Q16S;
  assign lh1_x = SW'(lgh1) - 40'sd2 * Q16S;

  logic signed [SW-1:0] slope_full;
  logic signed [30:0]   slope_r;

  assign slope_full = 40'sd4490 * Q16S - 40'sd655 * lh_x;

  always_ff @(posedge clk) begin
    slope_r <= slope_full[30:0];
  end

  // ---------------- item pipeline control ----------------
  logic [NS:1] v_r;
  logic [NS:1] rdy;

  always_comb begin
    rdy[NS] = !v_r[NS] || !out_stall;
    for (int k = NS - 1; k >= 1; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[1]) v_r[1] <= in_valid;
      for (int k = 2; k <= NS; k++) begin
        if (rdy[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  assign in_stall  = !rdy[1];
  assign out_valid = v_r[NS];

  // ---------------- stages 1-3: distance log, breakpoint ----------------
  logic [15:0] d_cl;
  logic [ump_pkg::LG_W-1:0] lgd;

  assign d_cl = (in_data.link_distance < DMIN) ? DMIN : in_data.link_distance;

  ump_log10 #(.DEPTH(LOG_TABLE_DEPTH), .L2_SUB(DIST_FRAC_BITS * 65536)) u_lg_d (
    .clk(clk), .en(rdy[3:1]), .x(d_cl), .lg(lgd)
  );

  logic [35:0] lhs1_r, lhs2_r;
  logic        nl1_r, nl2_r, nl3_r, bp3_r;
  logic [9:0]  ex1_r, ex2_r, ex3_r;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      lhs1_r <= 36'(d_cl) * 36'd750000;
      nl1_r  <= in_data.nlos_building;
      ex1_r  <= in_data.added_loss;
    end
    if (rdy[2]) begin
      lhs2_r <= lhs1_r;
      nl2_r  <= nl1_r;
      ex2_r  <= ex1_r;
    end
    if (rdy[3]) begin
      bp3_r <= RHSW'(lhs2_r) <= rhs_r;
      nl3_r <= nl2_r;
      ex3_r <= ex2_r;
    end
  end

  // ---------------- stage 4: constant-coefficient terms ----------------
  logic signed [SW-1:0] ld_x, los_near, los_far;
  logic signed [SW-1:0] fs4_r, los4_r, nlb4_r;
  logic signed [20:0]   ld4_r;
  logic                 nl4_r;
  logic [9:0]           ex4_r;
  ump_pkg::regime_t     rg4_r;

  assign ld_x     = SW'(lgd);
  assign los_near = 40'sd2270 * ld_x + 40'sd2700 * Q16S + 40'sd2000 * lf_x;
  assign los_far  = 40'sd4000 * ld_x + 40'sd756 * Q16S - 40'sd3460 * lh1_x
                  + 40'sd270 * lf_x;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      fs4_r  <= 40'sd2000 * ld_x + 40'sd4640 * Q16S + 40'sd2000 * lf5_x;
      los4_r <= bp3_r ? los_near : los_far;
      nlb4_r <= 40'sd583 * lh_x + 40'sd1338 * Q16S + 40'sd2300 * lf_x;
      ld4_r  <= 21'(lgd);
      nl4_r  <= nl3_r;
      ex4_r  <= ex3_r;
      rg4_r  <= nl3_r ? ump_pkg::RG_NLOS :
                bp3_r ? ump_pkg::RG_LOS_NEAR : ump_pkg::RG_LOS_FAR;
    end
  end

  // ---------------- stage 5: NLOS slope times log distance ----------------
  logic signed [51:0]   prod5_r;
  logic signed [SW-1:0] fs5_r, los5_r, nlb5_r;
  logic                 nl5_r;
  logic [9:0]           ex5_r;
  ump_pkg::regime_t     rg5_r;

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      prod5_r <= slope_r * ld4_r;
      fs5_r   <= fs4_r;
      los5_r  <= los4_r;
      nlb5_r  <= nlb4_r;
      nl5_r   <= nl4_r;
      ex5_r   <= ex4_r;
      rg5_r   <= rg4_r;
    end
  end

  // ---------------- stage 6: formula ----------------
  logic signed [51:0]   prod_sh;
  logic signed [SW-1:0] form6_r, fs6_r;
  logic                 nl6_r;
  logic [9:0]           ex6_r;
  ump_pkg::regime_t     rg6_r;

  // product is never negative, so the shift truncates like the division
  assign prod_sh = prod5_r >>> 16;

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      form6_r <= nl5_r ? SW'(prod_sh) + nlb5_r : los5_r;
      fs6_r   <= fs5_r;
      nl6_r   <= nl5_r;
      ex6_r   <= ex5_r;
      rg6_r   <= rg5_r;
    end
  end

  // ---------------- stage 7: free-space floor, added loss ----------------
  logic                 fs_win;
  logic signed [SW-1:0] sel7, ext7;
  logic signed [SW-1:0] s7_r;
  ump_pkg::regime_t     rg7_r;

  assign fs_win = fs6_r > form6_r;
  assign sel7   = fs_win ? fs6_r : form6_r;
  assign ext7   = nl6_r ? '0 : SW'(ex6_r) * 40'sd25600;

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      s7_r  <= sel7 + ext7;
      rg7_r <= fs_win ? ump_pkg::RG_FREE_SPACE : rg6_r;
    end
  end

  // ---------------- stages 8-10: round, divide by 409600, saturate ----------------
  // 409600 = 2^14 * 25: shift first, then divide by 25 via reciprocal
  logic signed [SW-1:0] t_full;
  logic [16:0]          t8_r, t9_r;
  logic                 sat8_r, pos8_r, sat9_r, pos9_r;
  logic [12:0]          q9_r;
  logic [36:0]          qprod;
  ump_pkg::regime_t     rg8_r, rg9_r;

  assign t_full = (s7_r + 40'sd204800) >>> 14;
  assign qprod  = 37'(t8_r) * 37'd671088;

  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      t8_r   <= t_full[16:0];
      sat8_r <= t_full >= 40'sd102400;
      pos8_r <= s7_r > 40'sd0;
      rg8_r  <= rg7_r;
    end
    if (rdy[9]) begin
      q9_r   <= qprod[36:24];
      t9_r   <= t8_r;
      sat9_r <= sat8_r;
      pos9_r <= pos8_r;
      rg9_r  <= rg8_r;
    end
  end

  logic [16:0] rem;
  logic [12:0] q_fix;
  logic [11:0] loss_nxt;
  ump_pkg::out_t out_r;

  assign rem      = t9_r - 17'(q9_r) * 17'd25;
  assign q_fix    = (rem >= 17'd25) ? q9_r + 13'd1 : q9_r;
  assign loss_nxt = !pos9_r ? 12'd0 : sat9_r ? 12'hFFF : q_fix[11:0];

  always_ff @(posedge clk) begin
    if (rdy[10]) begin
      out_r.loss_db <= loss_nxt;
      out_r.regime  <= rg9_r;
    end
  end

  assign out_data = out_r;

  // ---------------- assertions ----------------
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&v_r))
    else $error("input stalled while a pipeline stage is empty");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> v_r[1])
    else $error("accepted beat did not enter stage 1");

  a_sat_output: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NS-1] && rdy[NS] && sat9_r && pos9_r |=> out_data.loss_db == 12'hFFF)
    else $error("saturated loss not reported as maximum");

endmodule

`default_nettype wire

@@ rtl/ump_log10.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Three-stage log10 in Q16: leading-one normalize, table lookup, scale by log10(2).
module ump_log10 #(
  parameter int DEPTH  = 256,
  parameter int L2_SUB = 0
) (
  input  wire logic                    clk,
  input  wire logic [2:0]              en,
  input  wire logic [15:0]             x,
  output logic      [ump_pkg::LG_W-1:0] lg
);

  localparam int IDXW = $clog2(DEPTH);
  localparam int DW   = $clog2(DEPTH + 1);
  localparam int PW   = 15 + DW;

  logic [15:0] rom [DEPTH];

  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_rom
    localparam logic [63:0] Z0 = (64'd1 << 30) + ((64'(gi) << 30) / DEPTH);
    assign rom[gi] = ump_pkg::log_frac(Z0);
  end

  // stage A: leading one and mantissa fraction
  logic [3:0]  lead;
  logic [15:0] norm;
  logic [3:0]  p_r;
  logic [14:0] m_r;

  always_comb begin
    lead = '0;
    for (int i = 0; i < 16; i++) begin
      if (x[i]) lead = 4'(i);
    end
  end

  assign norm = x << (4'd15 - lead);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p_r <= lead;
      m_r <= norm[14:0];
    end
  end

  // stage B: table index and log2
  logic [PW-1:0]   iprod;
  logic [IDXW-1:0] idx;
  logic [19:0]     l2_nxt;
  logic [19:0]     l2_r;

  assign iprod  = PW'(m_r) * PW'(DEPTH);
  assign idx    = iprod[IDXW+14:15];
  assign l2_nxt = {p_r, 16'd0} + 20'(rom[idx]) - 20'(L2_SUB);

  always_ff @(posedge clk) begin
    if (en[1]) l2_r <= l2_nxt;
  end

  // stage C: log10 = log2 * log10(2)
  logic [51:0] lprod;
  logic [ump_pkg::LG_W-1:0] lg_r;

  assign lprod = 52'(l2_r) * 52'(ump_pkg::LOG10_2_Q32);

  always_ff @(posedge clk) begin
    if (en[2]) lg_r <= lprod[51:32];
  end

  assign lg = lg_r;

endmodule

`default_nettype wire

@@ verif/ump_loss_checker.sv @@
`timescale 1ns / 1ps

module ump_loss_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  ump_pkg::in_t                in_data,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  ump_pkg::out_t               out_data,
  input  logic                        cfg_wr_en,
  input  logic                        cfg_addr,
  input  logic [ump_pkg::CFG_W-1:0]   cfg_wdata,
  output int                          fail_cnt,
  output int                          loss_pending,
  output int                          beats_checked
);

  longint        log_rom [256];
  longint        carrier_reg;
  longint        height_reg;
  ump_pkg::out_t loss_q [$];

  initial begin
    logic [63:0] z;
    longint acc;
    for (int i = 0; i < 256; i++) begin
      z   = (64'd1 << 30) + ((64'(i) << 30) / 256);
      acc = 0;
      for (int b = 15; b >= 0; b--) begin
        z = (z * z) >> 30;
        if (z >= (64'd1 << 31)) begin
          acc = acc | (longint'(1) << b);
          z   = z >> 1;
        end
      end
      log_rom[i] = acc;
    end
  end

  function automatic longint log2_fix(longint x);
    int p;
    logic [63:0] m;
    logic [63:0] idx;
    p = 31;
    if (x == 0) x = 1;
    while (((x >> p) & 1) == 0) p--;
    m   = 64'(x) << (30 - p);
    idx = ((m - (64'd1 << 30)) * 256) >> 30;
    if (idx > 255) idx = 255;
    return longint'(p) * 65536 + log_rom[idx];
  endfunction

  function automatic longint log10_fix(longint l2);
    return (l2 * 64'sd1292913986) / 64'sd4294967296;
  endfunction

  function automatic ump_pkg::out_t predict_loss(ump_pkg::in_t b);
    longint f, h, d, ld, lf, lf5, lh, lh1, fs, form, s, slope, res;
    logic [63:0] lhs, rhs;
    ump_pkg::regime_t rg;
    ump_pkg::out_t r;
    f = carrier_reg;
    h = height_reg;
    d = b.link_distance;
    if (f < 700) f = 700;
    if (f > 6000) f = 6000;
    if (h < 110) h = 110;
    if (h > 5000) h = 5000;
    if (d < 48) d = 48;
    ld  = log10_fix(log2_fix(d) - 4 * 65536);
    lf  = log10_fix(log2_fix(f)) - 3 * 65536;
    lf5 = log10_fix(log2_fix(f)) - log10_fix(log2_fix(5000));
    lh  = log10_fix(log2_fix(h)) - 2 * 65536;
    lh1 = log10_fix(log2_fix(h - 100)) - 2 * 65536;
    fs  = 2000 * ld + 4640 * 65536 + 2000 * lf5;
    if (b.nlos_building) begin
      slope = 4490 * 65536 - 655 * lh;
      form  = (slope * ld) / 65536 + 583 * lh + 1838 * 65536 + 2300 * lf - 500 * 65536;
      rg    = ump_pkg::RG_NLOS;
    end else begin
      lhs = 64'(d) * 750000;
      rhs = (64'(h - 100) * 64'(h - 100) * 64'(f)) << 4;
      if (lhs <= rhs) begin
        form = 2270 * ld + 2700 * 65536 + 2000 * lf;
        rg   = ump_pkg::RG_LOS_NEAR;
      end else begin
        form = 4000 * ld + 756 * 65536 - 2 * 1730 * lh1 + 270 * lf;
        rg   = ump_pkg::RG_LOS_FAR;
      end
    end
    // free space wins only when strictly larger
    if (fs > form) begin
      s  = fs;
      rg = ump_pkg::RG_FREE_SPACE;
    end else begin
      s = form;
    end
    if (!b.nlos_building) s = s + longint'(b.added_loss) * 25600;
    if (s <= 0) res = 0;
    else begin
      res = (s + 204800) / 409600;
      if (res > 4095) res = 4095;
    end
    r.loss_db = 12'(res);
    r.regime  = rg;
    return r;
  endfunction

  assign loss_pending = loss_q.size();

  always @(posedge clk) begin
    ump_pkg::out_t want;
    if (!rst_n) begin
      carrier_reg   <= 5900;
      height_reg    <= 150;
      fail_cnt      <= 0;
      beats_checked <= 0;
      loss_q.delete();
    end else begin
      if (cfg_wr_en) begin
        if (cfg_addr == ump_pkg::CFG_CARRIER) carrier_reg <= cfg_wdata;
        else height_reg <= cfg_wdata;
      end
      if (in_valid && !in_stall) loss_q = {loss_q, predict_loss(in_data)};
      if (out_valid && !out_stall) begin
        beats_checked <= beats_checked + 1;
        if (loss_q.size() == 0) begin
          $display("%0t: result beat with nothing expected: loss %0d regime %0d",
                   $time, out_data.loss_db, out_data.regime);
          fail_cnt <= fail_cnt + 1;
        end else begin
          want = loss_q.pop_front();
          if (want.loss_db !== out_data.loss_db || want.regime !== out_data.regime) begin
            $display("%0t: mismatch expected loss %0d regime %0d, got loss %0d regime %0d",
                     $time, want.loss_db, want.regime, out_data.loss_db, out_data.regime);
            fail_cnt <= fail_cnt + 1;
          end
        end
      end
    end
  end

endmodule

@@ verif/tb_urban_microcell_path_loss_top.sv @@
`timescale 1ns / 1ps

module tb_urban_microcell_path_loss_top;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  ump_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ump_pkg::out_t out_data;
  logic cfg_wr_en = 1'b0;
  logic cfg_addr = ump_pkg::CFG_CARRIER;
  logic [ump_pkg::CFG_W-1:0] cfg_wdata = '0;

  int fail_cnt, loss_pending, beats_checked;
  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_req = 0;
  bit hold_done = 0;
  int hold_left = 0;
  int cycles = 0;

  always #10 clk = ~clk;

  urban_microcell_path_loss_top u_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_wr_en, .cfg_addr, .cfg_wdata
  );

  ump_loss_checker u_chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_wr_en, .cfg_addr, .cfg_wdata,
    .fail_cnt, .loss_pending, .beats_checked
  );

  // receiver: random stall, plus one long hold-off
  always @(posedge clk) begin
    if (hold_req && !hold_done && hold_left == 0) hold_left = 300;
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      if (hold_left == 0) hold_done = 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_link(logic [15:0] d, logic n, logic [9:0] a);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{link_distance: d, nlos_building: n, added_loss: a};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (loss_pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [ump_pkg::CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    repeat (8) @(posedge clk);
  endtask

  task automatic random_links(int cnt);
    logic [15:0] d;
    for (int i = 0; i < cnt; i++) begin
      case ($urandom_range(3))
        0: d = 16'($urandom_range(80));
        1: d = 16'($urandom_range(65535));
        default: d = 16'($urandom_range(65535) >> $urandom_range(15));
      endcase
      send_link(d, 1'($urandom), 10'($urandom));
    end
  endtask

  int carriers [8] = '{5900, 700, 6000, 8191, 0, 2400, 699, 6001};
  int heights  [8] = '{150, 110, 5000, 8191, 0, 1000, 109, 5001};

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: distance extremes, both formulas, breakpoint edge at reset config
    send_link(16'd0, 1'b0, 10'd0);
    send_link(16'd1, 1'b1, 10'd1023);
    send_link(16'd47, 1'b0, 10'd1023);
    send_link(16'd48, 1'b1, 10'd0);
    send_link(16'd49, 1'b0, 10'd5);
    send_link(16'd314, 1'b0, 10'd0);
    send_link(16'd315, 1'b0, 10'd0);
    send_link(16'd65535, 1'b0, 10'd1023);
    send_link(16'd65535, 1'b1, 10'd1023);
    send_link(16'hAAAA, 1'b1, 10'h155);
    send_link(16'h5555, 1'b0, 10'h2AA);
    send_link(16'd1600, 1'b0, 10'd0);
    send_link(16'd1600, 1'b1, 10'd0);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      if (ph < 8) begin
        write_reg(ump_pkg::CFG_CARRIER, ump_pkg::CFG_W'(carriers[ph]));
        write_reg(ump_pkg::CFG_HEIGHT, ump_pkg::CFG_W'(heights[ph]));
      end else begin
        write_reg(ump_pkg::CFG_CARRIER, ump_pkg::CFG_W'($urandom));
        write_reg(ump_pkg::CFG_HEIGHT, ump_pkg::CFG_W'($urandom));
      end
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 61; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 61; end
        default: begin idle_pct = 18; stall_pct = 18; end
      endcase
      if (ph == 4) begin
        idle_pct = 0;
        stall_pct = 0;
        hold_req = 1;
      end
      random_links(78);
      drain();
    end

    repeat (20) @(posedge clk);
    $display("covered %0d result beats over 13 register settings, out-of-range values",
             beats_checked);
    $display("included, with sender gaps, receiver stalls and one long hold-off");
    if (fail_cnt == 0 && loss_pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
